// File: design/rist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rist_pkg
// Types and constants shared by the running statistics unit.
// ----------------------------------------------------------------------------
package rist_pkg;
    localparam int SAMPLE_WIDTH = 32;
    localparam logic [30:0] COUNT_LIMIT = 31'h7FFF_FFFF;
    localparam logic [31:0] MAX_S32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_S32 = 32'h8000_0000;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] sample;
    } t_in;

    typedef struct packed {
        logic [31:0] mean;
        logic [31:0] variance;
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [31:0] total;
        logic [30:0] count;
        logic [31:0] latest;
    } t_out;

    // Divider request/response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// File: design/rist_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rist_div
// Radix-2 restoring divider: signed dividend over positive divisor, rounded
// half away from zero. Divisor zero returns the dividend. 33 quotient steps;
// done pulses, registered, after the last step (the cycle after start for divisor zero).
// ----------------------------------------------------------------------------
module rist_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  rist_pkg::t_div_req i_req,
    output rist_pkg::t_div_rsp o_rsp
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_quo, n_quo;   // magnitude + d/2; bit 32 is shifted out first
    logic [31:0] r_div, n_div;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [31:0] r_res, n_res;

    logic [32:0] mag_a;
    logic [33:0] trial;
    logic [33:0] shifted;
    logic [31:0] qmag;

    always_comb begin
        mag_a   = i_req.dividend[31] ? {1'b0, 32'd0 - i_req.dividend}
                                     : {1'b0, i_req.dividend};
        shifted = {r_rem, r_quo[32]};
        trial   = shifted - {2'b00, r_div};
        qmag    = r_quo[31:0];
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_res   = r_res;
        if (i_req.start) begin
            if (i_req.divisor == 32'd0) begin
                n_done = 1'b1;
                n_res  = i_req.dividend;
            end else begin
                n_busy = 1'b1;
                n_cnt  = 6'd33;
                n_rem  = 33'd0;
                n_quo  = mag_a + {2'b00, i_req.divisor[31:1]};
                n_div  = i_req.divisor;
                n_neg  = i_req.dividend[31];
            end
        end else if (r_busy) begin
            // one quotient bit per cycle
            if (!trial[33]) begin
                n_rem = trial[32:0];
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = shifted[32:0];
                n_quo = {r_quo[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                qmag   = n_quo[31:0];
                n_res  = r_neg ? 32'd0 - qmag : qmag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_res;
endmodule
`default_nettype wire

// File: design/running_integer_statistics_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_integer_statistics_unit
// Running count, sum, min, max, last sample, and residual mean/variance.
// ----------------------------------------------------------------------------
// With two or more samples counted, an accepted sample runs four divisions on the
// shared radix-2 divider plus seven multiply and output steps. The first sample
// runs only the mean division, a sample at the count limit only the output
// divisions, and a clear none. The output step waits while the output register is stalled.
// One transaction at a time; the next input is taken the cycle after the result
// is loaded into the output register. Reset: synchronous active low, cleared state.
module running_integer_statistics_unit (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  rist_pkg::t_in  i_data,
    output logic           o_valid,
    input  wire            i_stall,
    output rist_pkg::t_out o_data
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DM    = 14'b00000000000010,
        S_DMW   = 14'b00000000000100,
        S_M1    = 14'b00000000001000,
        S_M2    = 14'b00000000010000,
        S_M3    = 14'b00000000100000,
        S_M4    = 14'b00000001000000,
        S_M5    = 14'b00000010000000,
        S_DV    = 14'b00000100000000,
        S_DVW   = 14'b00001000000000,
        S_M6    = 14'b00010000000000,
        S_OM    = 14'b00100000000000,
        S_OV    = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [30:0] r_n;
    logic [31:0] r_mb, r_mr, r_vb, r_vr, r_sum, r_max, r_min, r_last;
    logic [31:0] r_pd, r_dm, r_t, r_w, r_om, r_ov;
    logic        r_pend;   // divide launched, waiting
    logic        r_ovld;
    rist_pkg::t_out r_odata;

    rist_pkg::t_div_req div_req;
    rist_pkg::t_div_rsp div_rsp;

    rist_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // shared 32x32 multiplier (low word)
    logic [31:0] mul_a, mul_b, mul_p;
    assign mul_p = mul_a * mul_b;

    logic [31:0] x, diff, nm1;
    logic        out_free;
    // sample is sign-extended from its low SAMPLE_WIDTH bits
    assign x        = 32'($signed(i_data.sample[rist_pkg::SAMPLE_WIDTH-1:0]));
    assign nm1      = {1'b0, r_n} - 32'd1;
    assign out_free = !r_ovld || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // divider operand and multiplier operand selection
    always_comb begin
        div_req = '0;
        mul_a   = r_dm;
        mul_b   = {1'b0, r_n};
        unique case (r_state)
            S_DM: begin
                div_req.start = !r_pend;
                div_req.dividend = r_pd;
                div_req.divisor  = {1'b0, r_n};
            end
            S_DV: begin
                div_req.start = !r_pend;
                div_req.dividend = r_w;
                div_req.divisor  = nm1;
            end
            S_OM: begin
                div_req.start = !r_pend && (r_n > 31'd1);
                div_req.dividend = r_mr;
                div_req.divisor  = {1'b0, r_n};
            end
            S_OV: begin
                div_req.start = !r_pend && (r_n > 31'd1);
                div_req.dividend = r_vr;
                div_req.divisor  = nm1;
            end
            S_M1: begin mul_a = r_dm; mul_b = {1'b0, r_n}; end
            S_M2: begin mul_a = r_t;  mul_b = r_t; end
            S_M3: begin mul_a = r_dm; mul_b = r_pd; end
            S_M4: begin mul_a = r_dm; mul_b = r_dm; end
            S_M5: begin mul_a = r_t;  mul_b = {1'b0, r_n}; end
            S_M6: begin mul_a = r_dm; mul_b = nm1; end
            default: ;
        endcase
    end

    assign diff = x - r_mb;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
            r_n     <= '0;
            r_mb    <= '0;
            r_mr    <= '0;
            r_vb    <= '0;
            r_vr    <= '0;
            r_sum   <= '0;
            r_max   <= rist_pkg::MIN_S32;
            r_min   <= rist_pkg::MAX_S32;
            r_last  <= '0;
        end else begin
            // output register: load a new result or drop an accepted one
            if (r_state == S_OUT && out_free) r_ovld <= 1'b1;
            else if (!i_stall) r_ovld <= 1'b0;
            if (div_req.start) r_pend <= 1'b1;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    if (i_data.opcode == rist_pkg::OP_CLEAR) begin
                        r_n <= '0; r_mb <= '0; r_mr <= '0; r_vb <= '0;
                        r_vr <= '0; r_sum <= '0; r_last <= '0;
                        r_max <= rist_pkg::MIN_S32;
                        r_min <= rist_pkg::MAX_S32;
                        r_state <= S_OM;
                    end else begin
                        r_last <= x;
                        if (r_n == rist_pkg::COUNT_LIMIT) begin
                            r_state <= S_OM;
                        end else begin
                            r_n   <= r_n + 31'd1;
                            r_sum <= r_sum + x;
                            if ($signed(x) > $signed(r_max)) r_max <= x;
                            if ($signed(x) < $signed(r_min)) r_min <= x;
                            r_t   <= diff;
                            r_pd  <= r_mr + diff;
                            r_state <= S_DM;
                        end
                    end
                end
                S_DM: if (div_rsp.done) begin
                    r_pend <= 1'b0;
                    r_dm <= div_rsp.quotient;
                    r_mb <= r_mb + div_rsp.quotient;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_mr <= r_pd - mul_p;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_w <= r_vr + mul_p - r_vb;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_w <= r_w - {mul_p[30:0], 1'b0};
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_t <= mul_p;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_w <= r_w + mul_p;
                    r_state <= (r_n > 31'd1) ? S_DV : S_OM;
                end
                S_DV: if (div_rsp.done) begin
                    r_pend <= 1'b0;
                    r_dm <= div_rsp.quotient;
                    r_vb <= r_vb + div_rsp.quotient;
                    r_state <= S_M6;
                end
                S_M6: begin
                    r_vr <= r_w - mul_p;
                    r_state <= S_OM;
                end
                S_OM: begin
                    if (r_n <= 31'd1) begin
                        r_om <= r_sum;
                        r_state <= S_OV;
                    end else if (div_rsp.done) begin
                        r_pend <= 1'b0;
                        r_om <= r_mb + div_rsp.quotient;
                        r_state <= S_OV;
                    end
                end
                S_OV: begin
                    if (r_n <= 31'd1) begin
                        r_ov <= '0;
                        r_state <= S_OUT;
                    end else if (div_rsp.done) begin
                        r_pend <= 1'b0;
                        r_ov <= r_vb + div_rsp.quotient;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (out_free) begin
                    r_state <= S_IDLE;
                end
                S_DMW, S_DVW: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_odata.mean     <= r_om;
            r_odata.variance <= r_ov;
            r_odata.minimum  <= (r_n == '0) ? '0 : r_min;
            r_odata.maximum  <= (r_n == '0) ? '0 : r_max;
            r_odata.total    <= r_sum;
            r_odata.count    <= r_n;
            r_odata.latest   <= r_last;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_odata;
endmodule
`default_nettype wire
